/* hdl/ltes_pkg.sv */
// ----------------------------------------------------------------------------
// ltes_pkg
// Shared widths, index constants and the per-entry tag for the linear
// triangle element stiffness block.
// ----------------------------------------------------------------------------
`default_nettype none

package ltes_pkg;

    localparam int COORD_W            = 32;
    localparam int DIFF_W             = COORD_W + 1;
    localparam int PROD_W             = 2 * DIFF_W;
    localparam int JAC_W              = PROD_W + 1;
    localparam int MAG_W              = JAC_W;
    localparam int DEN_W              = MAG_W + 1;
    localparam int QUOT_W             = 33;
    localparam int ENTRY_W            = 32;
    localparam int IDX_W              = 2;
    localparam int BASIS_N            = 3;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam logic [IDX_W-1:0] FIRST_IDX = '0;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BASIS_N - 1);

    // Largest positive and negative entry magnitudes.
    localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(33'h0_7FFF_FFFF);
    localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(33'h0_8000_0000);

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [IDX_W-1:0] test_idx;
        logic [IDX_W-1:0] trial_idx;
        logic             degen;
        logic             last;
        logic             neg;
    } entry_tag_t;

endpackage

`default_nettype wire

/* hdl/ltes_div.sv */
// ----------------------------------------------------------------------------
// ltes_div
// Pipelined restoring divider: one quotient bit per stage, with an overflow
// check in front for quotients that do not fit in QUOT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ltes_div #(
    parameter int FRACTION_BITS = ltes_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        in_valid,
    input  wire logic [ltes_pkg::MAG_W+FRACTION_BITS:0]      in_num,
    input  wire logic [ltes_pkg::DEN_W-1:0]                  in_den,
    input  wire ltes_pkg::entry_tag_t                        in_tag,
    output logic                                             out_valid,
    output logic [ltes_pkg::QUOT_W-1:0]                      out_quot,
    output logic                                             out_ovf,
    output ltes_pkg::entry_tag_t                             out_tag
);
    import ltes_pkg::*;

    localparam int NW = MAG_W + FRACTION_BITS + 1;
    localparam int RW = NW + QUOT_W + 1;

    logic [RW-1:0]     rem_reg   [0:QUOT_W-1];
    logic [DEN_W-1:0]  den_reg   [0:QUOT_W-1];
    logic [QUOT_W-1:0] quot_reg  [0:QUOT_W];
    logic              ovf_reg   [0:QUOT_W];
    entry_tag_t        tag_reg   [0:QUOT_W];
    logic              valid_reg [0:QUOT_W];

    logic [RW-1:0] num_ext;
    logic [RW-1:0] den_top;

    assign num_ext = RW'(in_num);
    assign den_top = RW'(in_den) << QUOT_W;

    // Front stage: a quotient of 2^QUOT_W or more is flagged and clamped later.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_ext;
        den_reg[0]  <= in_den;
        quot_reg[0] <= '0;
        ovf_reg[0]  <= (num_ext >= den_top);
        tag_reg[0]  <= in_tag;
    end

    for (genvar k = 1; k <= QUOT_W; k++)
    begin : g_stage
        localparam int SH = QUOT_W - k;
        logic [RW-1:0] den_sh;
        logic          take;

        assign den_sh = RW'(den_reg[k-1]) << SH;
        assign take   = (rem_reg[k-1] >= den_sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            quot_reg[k] <= quot_reg[k-1] | (take ? (QUOT_W'(1) << SH) : '0);
            ovf_reg[k]  <= ovf_reg[k-1];
            tag_reg[k]  <= tag_reg[k-1];
        end

        if (k < QUOT_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - den_sh) : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W];
    assign out_quot  = quot_reg[QUOT_W];
    assign out_ovf   = ovf_reg[QUOT_W];
    assign out_tag   = tag_reg[QUOT_W];

`ifndef ASSERT_OFF
    // Every item comes out and none is invented; a zero numerator gives a zero
    // quotient; a non-overflow quotient stays below 2^QUOT_W by width.
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(QUOT_W + 1) out_valid)
        else $error("ltes_div: item lost in divider pipeline");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> ##(QUOT_W + 1) !out_valid)
        else $error("ltes_div: item invented in divider pipeline");
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_num == '0 && in_den != '0) |-> ##(QUOT_W + 1)
            (out_quot == '0 && !out_ovf))
        else $error("ltes_div: zero numerator gave nonzero quotient");
`endif

endmodule

`default_nettype wire

/* hdl/linear_triangle_element_stiffness.sv */
// ----------------------------------------------------------------------------
// linear_triangle_element_stiffness
// Nine entries of the P1 triangle stiffness matrix, coefficient 1, emitted
// row by row with rounding to nearest and saturation to 32 bits.
//
//   Channel  Handshake        Payload
//   -------  ---------------  ----------------------------------------------
//   input    start / busy     vertex1_x .. vertex3_y
//   result   valid (strobe)   test_local_index, trial_local_index,
//                             stiffness_entry, degenerate, saturated,
//                             last_entry
//
// One triangle gives nine results on consecutive cycles; the single result
// port sets the sustained triangle rate.
// The first result reaches the ports through 40 register stages: two front
// stages, the entry sequencer, two product stages, the 34-stage divider and
// the result register.
// A new triangle is taken while the previous one is still in flight; busy
// rises only while the front stages wait for the sequencer. Reset clears valid
// bits and the sequencer indices. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_triangle_element_stiffness #(
    parameter int FRACTION_BITS = ltes_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex1_x,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex1_y,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex2_x,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex2_y,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex3_x,
    input  wire logic signed [ltes_pkg::COORD_W-1:0]   vertex3_y,
    output logic                                       valid,
    output logic [ltes_pkg::IDX_W-1:0]                 test_local_index,
    output logic [ltes_pkg::IDX_W-1:0]                 trial_local_index,
    output logic signed [ltes_pkg::ENTRY_W-1:0]        stiffness_entry,
    output logic                                       degenerate,
    output logic                                       saturated,
    output logic                                       last_entry
);
    import ltes_pkg::*;

    localparam int NW = MAG_W + FRACTION_BITS + 1;

    // ---------------- front: differences, then area products ----------------
    logic  f1_v_reg, f1_v_next;
    logic  f2_v_reg, f2_v_next;
    diff_t f1_gx_reg [0:BASIS_N-1];
    diff_t f1_gy_reg [0:BASIS_N-1];
    diff_t f2_gx_reg [0:BASIS_N-1];
    diff_t f2_gy_reg [0:BASIS_N-1];
    prod_t f2_p1_reg, f2_p2_reg;

    logic accept, f1_adv, f2_ready, f2_adv;

    // ---------------- entry sequencer ----------------
    logic             iss_v_reg, iss_v_next;
    diff_t            iss_gx_reg [0:BASIS_N-1];
    diff_t            iss_gy_reg [0:BASIS_N-1];
    logic [MAG_W-1:0] iss_jmag_reg;
    logic             iss_degen_reg;
    logic [IDX_W-1:0] iss_b_reg, iss_b_next;
    logic [IDX_W-1:0] iss_a_reg, iss_a_next;
    logic             iss_last, iss_free;

    logic signed [JAC_W-1:0] jac;
    logic [MAG_W-1:0]        jmag;

    // ---------------- entry products ----------------
    logic             e1_v_reg;
    prod_t            e1_pxx_reg, e1_pyy_reg;
    logic [MAG_W-1:0] e1_jmag_reg;
    entry_tag_t       e1_tag_reg;
    entry_tag_t       iss_tag;

    logic             e2_v_reg;
    logic [MAG_W-1:0] e2_nmag_reg;
    logic [MAG_W-1:0] e2_jmag_reg;
    entry_tag_t       e2_tag_reg;

    logic signed [JAC_W-1:0] e1_sum;
    logic                    e1_neg;
    entry_tag_t              e1_tag_sum;

    logic [NW-1:0]    div_num;
    logic [DEN_W-1:0] div_den;

    logic              dv_valid;
    logic [QUOT_W-1:0] dv_quot;
    logic              dv_ovf;
    entry_tag_t        dv_tag;

    logic [QUOT_W-1:0] limit, mag_out;
    logic              sat_now;
    logic [ENTRY_W-1:0] entry_now;

    logic               valid_reg;
    logic [IDX_W-1:0]   test_reg, trial_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic               degen_reg, sat_reg, last_reg;

    function automatic diff_t pick3(input diff_t v0, input diff_t v1, input diff_t v2,
                                    input logic [IDX_W-1:0] idx);
        diff_t r;
        case (idx)
            2'd0:    r = v0;
            2'd1:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    // ---------------- handshake and advance ----------------
    assign iss_last = (iss_b_reg == LAST_IDX) && (iss_a_reg == LAST_IDX);
    assign iss_free = !iss_v_reg || iss_last;
    assign f2_ready = !f2_v_reg || iss_free;
    assign f2_adv   = f2_v_reg && iss_free;
    assign busy     = f1_v_reg && !f2_ready;
    assign accept   = start && !busy;
    assign f1_adv   = f1_v_reg && f2_ready;

    always_comb
    begin
        f1_v_next = accept ? 1'b1 : (f1_adv ? 1'b0 : f1_v_reg);
        f2_v_next = f1_adv ? 1'b1 : (f2_adv ? 1'b0 : f2_v_reg);

        iss_v_next = iss_v_reg;
        iss_b_next = iss_b_reg;
        iss_a_next = iss_a_reg;
        if (f2_adv)
        begin
            iss_v_next = 1'b1;
            iss_b_next = FIRST_IDX;
            iss_a_next = FIRST_IDX;
        end
        else if (iss_v_reg)
        begin
            if (iss_last)
            begin
                iss_v_next = 1'b0;
            end
            else if (iss_a_reg == LAST_IDX)
            begin
                iss_a_next = FIRST_IDX;
                iss_b_next = iss_b_reg + IDX_W'(1);
            end
            else
            begin
                iss_a_next = iss_a_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            iss_v_reg <= 1'b0;
            iss_b_reg <= FIRST_IDX;
            iss_a_reg <= FIRST_IDX;
            e1_v_reg  <= 1'b0;
            e2_v_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg  <= f1_v_next;
            f2_v_reg  <= f2_v_next;
            iss_v_reg <= iss_v_next;
            iss_b_reg <= iss_b_next;
            iss_a_reg <= iss_a_next;
            e1_v_reg  <= iss_v_reg;
            e2_v_reg  <= e1_v_reg;
            valid_reg <= dv_valid;
        end
    end

    // ---------------- front payload ----------------
    // The area terms reuse the edge differences:
    // J = (x2-x1)(y3-y1) - (x3-x1)(y2-y1) = gy2*gx1 - gy1*gx2.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_gx_reg[0] <= DIFF_W'(vertex2_y) - DIFF_W'(vertex3_y);
            f1_gx_reg[1] <= DIFF_W'(vertex3_y) - DIFF_W'(vertex1_y);
            f1_gx_reg[2] <= DIFF_W'(vertex1_y) - DIFF_W'(vertex2_y);
            f1_gy_reg[0] <= DIFF_W'(vertex3_x) - DIFF_W'(vertex2_x);
            f1_gy_reg[1] <= DIFF_W'(vertex1_x) - DIFF_W'(vertex3_x);
            f1_gy_reg[2] <= DIFF_W'(vertex2_x) - DIFF_W'(vertex1_x);
        end
        if (f1_adv)
        begin
            f2_gx_reg <= f1_gx_reg;
            f2_gy_reg <= f1_gy_reg;
            f2_p1_reg <= f1_gy_reg[2] * f1_gx_reg[1];
            f2_p2_reg <= f1_gy_reg[1] * f1_gx_reg[2];
        end
    end

    assign jac  = JAC_W'(f2_p1_reg) - JAC_W'(f2_p2_reg);
    assign jmag = jac[JAC_W-1] ? MAG_W'(-jac) : MAG_W'(jac);

    always_ff @(posedge clk)
    begin
        if (f2_adv)
        begin
            iss_gx_reg    <= f2_gx_reg;
            iss_gy_reg    <= f2_gy_reg;
            iss_jmag_reg  <= jmag;
            iss_degen_reg <= (jmag == '0);
        end
    end

    // ---------------- entry products ----------------
    always_comb
    begin
        iss_tag.test_idx  = iss_b_reg;
        iss_tag.trial_idx = iss_a_reg;
        iss_tag.degen     = iss_degen_reg;
        iss_tag.last      = iss_last;
        iss_tag.neg       = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        e1_pxx_reg  <= pick3(iss_gx_reg[0], iss_gx_reg[1], iss_gx_reg[2], iss_a_reg)
                     * pick3(iss_gx_reg[0], iss_gx_reg[1], iss_gx_reg[2], iss_b_reg);
        e1_pyy_reg  <= pick3(iss_gy_reg[0], iss_gy_reg[1], iss_gy_reg[2], iss_a_reg)
                     * pick3(iss_gy_reg[0], iss_gy_reg[1], iss_gy_reg[2], iss_b_reg);
        e1_jmag_reg <= iss_jmag_reg;
        e1_tag_reg  <= iss_tag;
    end

    assign e1_sum = JAC_W'(e1_pxx_reg) + JAC_W'(e1_pyy_reg);
    assign e1_neg = e1_sum[JAC_W-1];

    always_comb
    begin
        e1_tag_sum     = e1_tag_reg;
        e1_tag_sum.neg = e1_neg;
    end

    always_ff @(posedge clk)
    begin
        e2_nmag_reg <= e1_neg ? MAG_W'(-e1_sum) : MAG_W'(e1_sum);
        e2_jmag_reg <= e1_jmag_reg;
        e2_tag_reg  <= e1_tag_sum;
    end

    // Adding |J| before dividing by 2|J| rounds half away from zero.
    assign div_num = (NW'(e2_nmag_reg) << FRACTION_BITS) + NW'(e2_jmag_reg);
    assign div_den = {e2_jmag_reg, 1'b0};

    ltes_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e2_v_reg),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_tag    (e2_tag_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_ovf   (dv_ovf),
        .out_tag   (dv_tag)
    );

    // ---------------- saturation and result register ----------------
    assign limit     = dv_tag.neg ? NEG_LIMIT : POS_LIMIT;
    assign sat_now   = !dv_tag.degen && (dv_ovf || (dv_quot > limit));
    assign mag_out   = (dv_ovf || (dv_quot > limit)) ? limit : dv_quot;
    assign entry_now = dv_tag.degen ? '0
                     : (dv_tag.neg ? ENTRY_W'(-mag_out) : ENTRY_W'(mag_out));

    always_ff @(posedge clk)
    begin
        test_reg  <= dv_tag.test_idx;
        trial_reg <= dv_tag.trial_idx;
        entry_reg <= entry_now;
        degen_reg <= dv_tag.degen;
        sat_reg   <= sat_now;
        last_reg  <= dv_tag.last;
    end

    assign valid             = valid_reg;
    assign test_local_index  = test_reg;
    assign trial_local_index = trial_reg;
    assign stiffness_entry   = entry_reg;
    assign degenerate        = degen_reg;
    assign saturated         = sat_reg;
    assign last_entry        = last_reg;

`ifndef ASSERT_OFF
    a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (f1_v_reg && f2_v_reg && iss_v_reg))
        else $error("busy raised with a free front stage");
    a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_v_reg && !iss_last) |=> iss_v_reg)
        else $error("entry sequencer dropped a triangle mid-matrix");
    a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last_entry) |-> (test_local_index == LAST_IDX
                                   && trial_local_index == LAST_IDX))
        else $error("last entry flagged off the final matrix position");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && degenerate) |-> (stiffness_entry == '0 && !saturated))
        else $error("degenerate triangle gave a nonzero or clamped entry");
`endif

endmodule

`default_nettype wire
